// ===== hdl/lbs_pkg.sv =====
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared constants, types and helpers of the linear blend skinning block:
// field widths, matrix store geometry, controller state and command types.
// ----------------------------------------------------------------------------
package lbs_pkg;

   // joints held in the matrix store
   localparam int MAX_JOINTS      = 64;
   localparam int ELEMS_PER_JOINT = 12;
   localparam int MAT_ROWS        = 4;
   localparam int MAT_COLS        = 3;

   // field widths
   localparam int JOINT_W  = 6;
   localparam int ELEM_W   = 4;
   localparam int DATA_W   = 32;
   localparam int WEIGHT_W = 16;

   // one bank per matrix row, addressed by joint*3 + column
   localparam int BANK_DEPTH  = MAX_JOINTS * MAT_COLS;
   localparam int ADDR_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
   localparam int ADDR_CALC_W = (ADDR_W > JOINT_W + 2) ? ADDR_W : JOINT_W + 2;
   localparam int COL_W       = 2;

   // arithmetic widths
   localparam int PROD_W = 2 * DATA_W;          // exact point * element
   localparam int T_W    = 50;                  // transformed coordinate
   localparam int TW_W   = T_W + WEIGHT_W + 1;  // coordinate * weight
   localparam int ACC_W  = 64;                  // running sums
   localparam int FRAC_W = 16;                  // Q16.16 fraction bits
   localparam int WFRAC_W = 15;                 // Q1.15 fraction bits

   localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(32768);

   // command codes
   localparam logic CMD_LOAD    = 1'b0;
   localparam logic CMD_CONTRIB = 1'b1;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN,
      ST_EMIT
   } lbs_state_type;

   // controller to datapath
   typedef struct packed {
      logic             capture;    // latch point, weight and joint of an item
      logic             mem_write;  // write one matrix element
      logic             issue;      // start one column through the pipeline
      logic [COL_W-1:0] col;        // column being issued
      logic             emit;       // move saturated sums to output, clear sums
   } lbs_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic pipe_busy;  // a column is still in flight
      logic rsp_full;   // output register holds an item that is not taken
   } lbs_status_type;

   // joint lies inside the store
   function automatic logic joint_in_range(input logic [JOINT_W-1:0] joint);
      return (int'(joint) < MAX_JOINTS);
   endfunction

   // matrix row of an element index
   function automatic logic [1:0] elem_row(input logic [ELEM_W-1:0] element);
      logic [1:0] row;
      if (element >= ELEM_W'(9)) begin
         row = 2'd3;
      end else if (element >= ELEM_W'(6)) begin
         row = 2'd2;
      end else if (element >= ELEM_W'(3)) begin
         row = 2'd1;
      end else begin
         row = 2'd0;
      end
      return row;
   endfunction

   // matrix column of an element index
   function automatic logic [COL_W-1:0] elem_col(input logic [ELEM_W-1:0] element);
      logic [ELEM_W-1:0] rest;
      rest = element - ELEM_W'(3) * ELEM_W'(elem_row(element));
      return rest[COL_W-1:0];
   endfunction

endpackage

// ===== hdl/lbs_req_if.sv =====
// ----------------------------------------------------------------------------
// lbs_req_if
// Request channel: matrix loads and weighted vertex contributions.
// ----------------------------------------------------------------------------
interface lbs_req_if
   import lbs_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic                       command;
   logic [JOINT_W-1:0]         joint;
   logic [ELEM_W-1:0]          element;
   logic signed [DATA_W-1:0]   matrix_value;
   logic [WEIGHT_W-1:0]        weight;
   logic signed [DATA_W-1:0]   point_x;
   logic signed [DATA_W-1:0]   point_y;
   logic signed [DATA_W-1:0]   point_z;
   logic                       last_contribution;

   modport source (
      output valid, command, joint, element, matrix_value, weight,
             point_x, point_y, point_z, last_contribution,
      input  ready
   );

   modport sink (
      input  valid, command, joint, element, matrix_value, weight,
             point_x, point_y, point_z, last_contribution,
      output ready
   );
endinterface

// ===== hdl/lbs_rsp_if.sv =====
// ----------------------------------------------------------------------------
// lbs_rsp_if
// Response channel: one skinned vertex per finished contribution group.
// ----------------------------------------------------------------------------
interface lbs_rsp_if
   import lbs_pkg::*;
();
   logic                       valid;
   logic                       ready;
   logic signed [DATA_W-1:0]   skinned_x;
   logic signed [DATA_W-1:0]   skinned_y;
   logic signed [DATA_W-1:0]   skinned_z;
   logic                       overflow;

   modport source (
      output valid, skinned_x, skinned_y, skinned_z, overflow,
      input  ready
   );

   modport sink (
      input  valid, skinned_x, skinned_y, skinned_z, overflow,
      output ready
   );
endinterface

// ===== hdl/lbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// lbs_ctrl
// Sequencer: accepts items, issues the three matrix columns of a
// contribution, waits for the pipeline to drain and hands off results.
// ----------------------------------------------------------------------------
module lbs_ctrl
   import lbs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_command,
   input  logic [JOINT_W-1:0] req_joint,
   input  logic               req_last,
   output logic               req_ready,
   input  lbs_status_type     status,
   output lbs_cmd_type        cmd
);

   lbs_state_type    state_ff, state_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic             last_ff, last_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         col_ff   <= '0;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         last_ff  <= last_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      col_in        = col_ff;
      last_in       = last_ff;
      req_ready     = 1'b0;
      cmd           = '0;
      cmd.col       = col_ff;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               last_in     = req_last;
               col_in      = '0;
               if (req_command == CMD_LOAD) begin
                  cmd.mem_write = 1'b1;
               end else if (joint_in_range(req_joint)) begin
                  state_in = ST_ISSUE;
               end else if (req_last) begin
                  state_in = ST_EMIT;
               end
            end
         end

         // one column per cycle
         ST_ISSUE: begin
            cmd.issue = 1'b1;
            if (col_ff == COL_W'(MAT_COLS - 1)) begin
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end

         ST_DRAIN: begin
            if (!status.pipe_busy) begin
               state_in = last_ff ? ST_EMIT : ST_IDLE;
            end
         end

         // wait for room in the output register
         ST_EMIT: begin
            if (!status.rsp_full) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hdl/lbs_datapath.sv =====
// ----------------------------------------------------------------------------
// lbs_datapath
// Matrix store in four row banks, the column pipeline (read, multiply,
// sum, weight), the three saturating accumulators and the output register.
// ----------------------------------------------------------------------------
module lbs_datapath
   import lbs_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  lbs_cmd_type              cmd,
   output lbs_status_type           status,
   input  logic [JOINT_W-1:0]       req_joint,
   input  logic [ELEM_W-1:0]        req_element,
   input  logic signed [DATA_W-1:0] req_matrix_value,
   input  logic [WEIGHT_W-1:0]      req_weight,
   input  logic signed [DATA_W-1:0] req_point_x,
   input  logic signed [DATA_W-1:0] req_point_y,
   input  logic signed [DATA_W-1:0] req_point_z,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [DATA_W-1:0] rsp_skinned_x,
   output logic signed [DATA_W-1:0] rsp_skinned_y,
   output logic signed [DATA_W-1:0] rsp_skinned_z,
   output logic                     rsp_overflow
);

   // item registers
   logic signed [DATA_W-1:0] pt_ff [MAT_COLS];
   logic [WEIGHT_W-1:0]      weight_ff;
   logic [JOINT_W-1:0]       joint_ff;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         pt_ff[0]  <= req_point_x;
         pt_ff[1]  <= req_point_y;
         pt_ff[2]  <= req_point_z;
         weight_ff <= (req_weight > WEIGHT_ONE) ? WEIGHT_ONE : req_weight;
         joint_ff  <= req_joint;
      end
   end

   // store addressing
   logic [1:0]             wr_row;
   logic [COL_W-1:0]       wr_col;
   logic                   wr_en;
   logic [ADDR_CALC_W-1:0] wr_addr_wide, rd_addr_wide;
   logic [ADDR_W-1:0]      wr_addr, rd_addr;

   always_comb begin
      wr_row       = elem_row(req_element);
      wr_col       = elem_col(req_element);
      wr_en        = cmd.mem_write && joint_in_range(req_joint)
                     && (int'(req_element) < ELEMS_PER_JOINT);
      wr_addr_wide = ADDR_CALC_W'(req_joint) * ADDR_CALC_W'(MAT_COLS)
                     + ADDR_CALC_W'(wr_col);
      rd_addr_wide = ADDR_CALC_W'(joint_ff) * ADDR_CALC_W'(MAT_COLS)
                     + ADDR_CALC_W'(cmd.col);
      wr_addr      = wr_addr_wide[ADDR_W-1:0];
      rd_addr      = rd_addr_wide[ADDR_W-1:0];
   end

   // stage 1: one bank per matrix row, all read at the column address
   logic signed [DATA_W-1:0] m1_ff [MAT_ROWS];
   logic                     v1_ff;
   logic [COL_W-1:0]         col1_ff;

   for (genvar r = 0; r < MAT_ROWS; r++) begin : g_bank
      logic [DATA_W-1:0] bank_mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en && (wr_row == 2'(r))) begin
            bank_mem[wr_addr] <= req_matrix_value;
         end
         if (cmd.issue) begin
            m1_ff[r] <= bank_mem[rd_addr];
         end
      end
   end

   // stage 2: point times matrix column, exact
   logic signed [PROD_W-1:0] prod2_ff [MAT_COLS];
   logic signed [DATA_W-1:0] trans2_ff;
   logic                     v2_ff;
   logic [COL_W-1:0]         col2_ff;

   always_ff @(posedge clock) begin
      for (int r = 0; r < MAT_COLS; r++) begin
         prod2_ff[r] <= pt_ff[r] * m1_ff[r];
      end
      trans2_ff <= m1_ff[MAT_ROWS-1];
   end

   // stage 3: floor to Q16.16 and add translation
   logic signed [T_W-1:0] t3_ff;
   logic signed [T_W-1:0] t_sum;
   logic                  v3_ff;
   logic [COL_W-1:0]      col3_ff;

   always_comb begin
      t_sum = T_W'(trans2_ff);
      for (int r = 0; r < MAT_COLS; r++) begin
         t_sum = t_sum + T_W'($signed(prod2_ff[r][PROD_W-1:FRAC_W]));
      end
   end

   always_ff @(posedge clock) begin
      t3_ff <= t_sum;
   end

   // stage 4: scale by weight
   logic signed [TW_W-1:0] tw4_ff;
   logic                   v4_ff;
   logic [COL_W-1:0]       col4_ff;

   always_ff @(posedge clock) begin
      tw4_ff <= t3_ff * $signed({1'b0, weight_ff});
   end

   // column tags through the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      col1_ff <= cmd.col;
      col2_ff <= col1_ff;
      col3_ff <= col2_ff;
      col4_ff <= col3_ff;
   end

   // saturating accumulate of the floor-scaled contribution
   logic signed [ACC_W-1:0] sum_ff [MAT_COLS];
   logic signed [ACC_W-1:0] contrib;
   logic signed [ACC_W:0]   acc_wide;
   logic signed [ACC_W-1:0] acc_sat;
   logic [COL_W-1:0]        acc_sel;

   always_comb begin
      acc_sel  = col4_ff;
      contrib  = ACC_W'($signed(tw4_ff[TW_W-1:WFRAC_W]));
      acc_wide = {sum_ff[acc_sel][ACC_W-1], sum_ff[acc_sel]} + {contrib[ACC_W-1], contrib};
      if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
         acc_sat = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                   : {1'b0, {(ACC_W-1){1'b1}}};
      end else begin
         acc_sat = acc_wide[ACC_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.emit) begin
         for (int c = 0; c < MAT_COLS; c++) begin
            sum_ff[c] <= '0;
         end
      end else if (v4_ff) begin
         sum_ff[acc_sel] <= acc_sat;
      end
   end

   // saturate sums to 32 bits
   logic signed [DATA_W-1:0] sat_val [MAT_COLS];
   logic [MAT_COLS-1:0]      sat_hit;

   always_comb begin
      for (int c = 0; c < MAT_COLS; c++) begin
         if (!sum_ff[c][ACC_W-1] && (|sum_ff[c][ACC_W-2:DATA_W-1])) begin
            sat_hit[c] = 1'b1;
            sat_val[c] = {1'b0, {(DATA_W-1){1'b1}}};
         end else if (sum_ff[c][ACC_W-1] && !(&sum_ff[c][ACC_W-2:DATA_W-1])) begin
            sat_hit[c] = 1'b1;
            sat_val[c] = {1'b1, {(DATA_W-1){1'b0}}};
         end else begin
            sat_hit[c] = 1'b0;
            sat_val[c] = sum_ff[c][DATA_W-1:0];
         end
      end
   end

   // output register
   logic                     rsp_valid_ff;
   logic signed [DATA_W-1:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic                     rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.emit) begin
         rsp_x_ff   <= sat_val[0];
         rsp_y_ff   <= sat_val[1];
         rsp_z_ff   <= sat_val[2];
         rsp_ovf_ff <= |sat_hit;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_skinned_x = rsp_x_ff;
   assign rsp_skinned_y = rsp_y_ff;
   assign rsp_skinned_z = rsp_z_ff;
   assign rsp_overflow  = rsp_ovf_ff;

   // status back to the sequencer
   assign status.pipe_busy = v1_ff | v2_ff | v3_ff | v4_ff;
   assign status.rsp_full  = rsp_valid_ff & ~rsp_ready;

endmodule

// ===== hdl/linear_blend_skinning_top.sv =====
// ----------------------------------------------------------------------------
// linear_blend_skinning_top
// Linear blend skinning in Q16.16: matrix store, per-joint weighted
// transform and per-vertex accumulation with 32-bit saturation.
// ----------------------------------------------------------------------------
// A load item writes one matrix element into one of four row banks. A
// contribution item issues the three matrix columns into a four-stage
// pipeline (bank read, three parallel 32x32 multiplies, sum with translation,
// weight multiply) one per cycle, followed by the drain of that pipeline into
// the accumulators; no new item is accepted until the drain ends. An item
// marked last then moves the saturated sums into the output register, waiting
// while that register still holds a result that is not taken; a new item is
// accepted while a result waits. A contribution for a joint outside the store
// adds nothing, but one marked last still moves the sums out. The matrix store
// needs no clearing after reset; an element must be loaded before a
// contribution reads it.
module linear_blend_skinning_top
   import lbs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   lbs_req_if.sink     req_bus,
   lbs_rsp_if.source   rsp_bus
);

   lbs_cmd_type    cmd;
   lbs_status_type status;

   // sequencer
   lbs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_command (req_bus.command),
      .req_joint   (req_bus.joint),
      .req_last    (req_bus.last_contribution),
      .req_ready   (req_bus.ready),
      .status      (status),
      .cmd         (cmd)
   );

   // store, arithmetic and output register
   lbs_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_joint        (req_bus.joint),
      .req_element      (req_bus.element),
      .req_matrix_value (req_bus.matrix_value),
      .req_weight       (req_bus.weight),
      .req_point_x      (req_bus.point_x),
      .req_point_y      (req_bus.point_y),
      .req_point_z      (req_bus.point_z),
      .rsp_valid        (rsp_bus.valid),
      .rsp_ready        (rsp_bus.ready),
      .rsp_skinned_x    (rsp_bus.skinned_x),
      .rsp_skinned_y    (rsp_bus.skinned_y),
      .rsp_skinned_z    (rsp_bus.skinned_z),
      .rsp_overflow     (rsp_bus.overflow)
   );

endmodule

// ===== hdl/lbs_checker.sv =====
// ----------------------------------------------------------------------------
// lbs_port_checker
// Port-level checks of the skinning block, bound to the top level.
// ----------------------------------------------------------------------------
module lbs_port_checker
   import lbs_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_ready,
   input logic                     req_command,
   input logic                     req_last,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic signed [DATA_W-1:0] rsp_x,
   input logic signed [DATA_W-1:0] rsp_y,
   input logic signed [DATA_W-1:0] rsp_z,
   input logic                     rsp_overflow
);

   localparam logic signed [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable({rsp_x, rsp_y, rsp_z, rsp_overflow}))
      else $error("result changed while stalled");

   // loads and non-final contributions raise no result in the next cycle
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_command == CMD_LOAD || !req_last) && !rsp_valid
      |=> !rsp_valid)
      else $error("result without a final contribution");

   // a contribution keeps the block busy in the following cycle
   a_contrib_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_command == CMD_CONTRIB |=> !req_ready)
      else $error("item accepted during a contribution");

   // overflow only with a saturated coordinate
   a_ovf_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflow |->
         rsp_x == SAT_MAX || rsp_x == SAT_MIN || rsp_y == SAT_MAX ||
         rsp_y == SAT_MIN || rsp_z == SAT_MAX || rsp_z == SAT_MIN)
      else $error("overflow flagged without saturation");

endmodule

bind linear_blend_skinning_top lbs_port_checker u_lbs_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_bus.valid),
   .req_ready    (req_bus.ready),
   .req_command  (req_bus.command),
   .req_last     (req_bus.last_contribution),
   .rsp_valid    (rsp_bus.valid),
   .rsp_ready    (rsp_bus.ready),
   .rsp_x        (rsp_bus.skinned_x),
   .rsp_y        (rsp_bus.skinned_y),
   .rsp_z        (rsp_bus.skinned_z),
   .rsp_overflow (rsp_bus.overflow)
);
